FILE: rtl/nfwa_pkg.sv
package nfwa_pkg;

  localparam int CELL_COUNT_DEF = 1024;
  localparam int WORD_W         = 32;
  localparam int FIELD_ADDR_W   = 10;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_READ  = 2'd2
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ
  } state_t;

  // one request as seen by the sequencer
  typedef struct packed {
    logic                    accept;
    req_kind_t               kind;
    logic [WORD_W-1:0]       word;
    logic [FIELD_ADDR_W-1:0] addr;
  } req_t;

  // one result, valid for a single cycle
  typedef struct packed {
    logic                    valid;
    logic                    ok;
    logic [FIELD_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]       value;
  } res_t;

endpackage

FILE: rtl/nfwa_ram.sv
module nfwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/nfwa_ctrl.sv
module nfwa_ctrl #(
  parameter int CELL_COUNT = nfwa_pkg::CELL_COUNT_DEF,
  parameter int ADDR_W     = $clog2(CELL_COUNT)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nfwa_pkg::req_t            req,
  output logic                      busy,
  output logic                      ram_we,
  output logic [ADDR_W-1:0]         ram_waddr,
  output logic [nfwa_pkg::WORD_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0]         ram_raddr,
  input  logic [nfwa_pkg::WORD_W-1:0] ram_rdata,
  output nfwa_pkg::res_t            res
);
  import nfwa_pkg::*;

  localparam int EXT_W = ADDR_W + FIELD_ADDR_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(CELL_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] cursor_r, cursor_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;       // next cell to read
  logic [ADDR_W-1:0] chk_pos_r, chk_pos_nxt; // cell whose data is on rdata
  logic [ADDR_W-1:0] chk_cnt_r, chk_cnt_nxt; // also the clear pass index
  logic [WORD_W-1:0] word_r, word_nxt;

  logic [EXT_W-1:0]  req_addr_ext;
  logic [ADDR_W-1:0] req_cell;
  logic              req_in_range;
  logic [EXT_W-1:0]  chk_pos_ext;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] p);
    wrap_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  assign req_addr_ext = {{ADDR_W{1'b0}}, req.addr};
  assign req_cell     = req_addr_ext[ADDR_W-1:0];
  assign req_in_range = req_addr_ext < EXT_W'(CELL_COUNT);
  assign chk_pos_ext  = {{FIELD_ADDR_W{1'b0}}, chk_pos_r};

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      cursor_r  <= '0;
      chk_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cursor_r  <= cursor_nxt;
      chk_cnt_r <= chk_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    chk_pos_r <= chk_pos_nxt;
    word_r    <= word_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cursor_nxt  = cursor_r;
    ptr_nxt     = ptr_r;
    chk_pos_nxt = chk_pos_r;
    chk_cnt_nxt = chk_cnt_r;
    word_nxt    = word_r;
    ram_we      = 1'b0;
    ram_waddr   = chk_pos_r;
    ram_wdata   = word_r;
    ram_raddr   = ptr_r;
    res         = '0;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = chk_cnt_r;
        ram_wdata   = '0;
        chk_cnt_nxt = chk_cnt_r + 1'b1;
        if (chk_cnt_r == LAST) begin
          chk_cnt_nxt = '0;
          state_nxt   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_raddr = cursor_r;
        if (req.accept) begin
          unique case (req.kind)
            REQ_ALLOC: begin
              ptr_nxt     = wrap_inc(cursor_r);
              chk_pos_nxt = cursor_r;
              chk_cnt_nxt = '0;
              word_nxt    = req.word;
              state_nxt   = ST_SCAN;
            end
            REQ_FREE: begin
              res.valid = 1'b1;
              res.ok    = req_in_range;
              ram_we    = req_in_range;
              ram_waddr = req_cell;
              ram_wdata = '0;
            end
            REQ_READ: begin
              ram_raddr = req_cell;
              if (req_in_range) begin
                state_nxt = ST_READ;
              end else begin
                res.valid = 1'b1;
              end
            end
            default: begin
              res.valid = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_rdata == '0) begin
          ram_we     = 1'b1;
          cursor_nxt = chk_pos_r;
          res.valid  = 1'b1;
          res.ok     = 1'b1;
          res.addr   = chk_pos_ext[FIELD_ADDR_W-1:0];
          state_nxt  = ST_IDLE;
        end else if (chk_cnt_r == LAST) begin
          res.valid = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          chk_cnt_nxt = chk_cnt_r + 1'b1;
          chk_pos_nxt = ptr_r;
          ptr_nxt     = wrap_inc(ptr_r);
        end
      end
      ST_READ: begin
        res.valid = 1'b1;
        res.ok    = 1'b1;
        res.value = ram_rdata;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CLEAR |-> !res.valid)
    else $error("result during clearing pass");

  a_alloc_enters_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && req.accept && req.kind == REQ_ALLOC |=> state_r == ST_SCAN)
    else $error("allocate did not start a scan");

  a_alloc_hits_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && res.valid && res.ok |-> ram_we && ram_rdata == '0)
    else $error("allocate stored into a used cell");

  a_fail_after_full_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN && res.valid && !res.ok |-> chk_cnt_r == LAST)
    else $error("allocate failed before visiting every cell");
`endif

endmodule

FILE: rtl/next_fit_word_allocator_top.sv
// Next-fit word allocator: a store of CELL_COUNT 32-bit cells in which a cell holding zero is
// free. A request is taken when start is high and busy is low. Allocate (req_type 0) scans
// forward from the kept cursor, wrapping at the end, stores in_data_word in the first free
// cell, reports its address and leaves the cursor there; it fails with ok 0 if every cell is
// used. Free (1) zeroes a cell, read (2) returns a cell; an address beyond the store and the
// unused code give ok 0. Every request gives exactly one result, shown on the out_ ports for a
// single cycle while out_valid is high; the receiver cannot stall it, so it must take each
// result as it appears. The scan walks the cell memory's one read port one cell per cycle,
// checking from 1 to CELL_COUNT cells per allocate. Free, unused and out-of-range read requests
// leave busy low; an in-range read and an allocate hold busy high until their result is given.
// The result is registered on the out_ ports. After reset the block writes zero to every cell
// with busy high before it takes its first request.
module next_fit_word_allocator_top #(
  parameter int CELL_COUNT = nfwa_pkg::CELL_COUNT_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  output logic                                        busy,
  input  logic [1:0]                                  in_req_type,
  input  logic signed [nfwa_pkg::WORD_W-1:0]          in_data_word,
  input  logic [nfwa_pkg::FIELD_ADDR_W-1:0]           in_cell_address,
  output logic                                        out_valid,
  output logic                                        out_ok,
  output logic [nfwa_pkg::FIELD_ADDR_W-1:0]           out_result_address,
  output logic signed [nfwa_pkg::WORD_W-1:0]          out_read_value
);
  import nfwa_pkg::*;

  localparam int ADDR_W = $clog2(CELL_COUNT);

  req_t              req;
  res_t              res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // result register: strobe is reset, payload is not
  logic                    out_valid_r;
  logic                    out_ok_r;
  logic [FIELD_ADDR_W-1:0] out_addr_r;
  logic [WORD_W-1:0]       out_value_r;

  // a request is taken only while the sequencer is idle
  assign req.accept = start & ~busy;
  assign req.kind   = req_kind_t'(in_req_type);
  assign req.word   = in_data_word;
  assign req.addr   = in_cell_address;

  // sequencer: clearing pass, next-fit scan, free and read
  nfwa_ctrl #(
    .CELL_COUNT (CELL_COUNT),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res       (res)
  );

  // cell store, one write and one registered read port
  nfwa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r    <= res.ok;
    out_addr_r  <= res.addr;
    out_value_r <= res.value;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_result_address = out_addr_r;
  assign out_read_value     = out_value_r;

endmodule
